// File: sv/bta_pkg.sv
// Shared types and constants for the binary to ASCII decimal converter.
// Used by bta_ctrl, bta_dpath and binary_to_ascii_decimal.
package bta_pkg;

	localparam int IN_W          = 64;  // width of the input number field
	localparam int CHAR_W        = 6;   // width of the digit character field
	localparam int DIGIT_BITS    = 4;   // one BCD digit
	localparam int BITS_PER_STEP = 4;   // binary bits folded into the BCD word per cycle

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;   // capture a new number
		logic shift;  // one double-dabble step
		logic size;   // latch index of leading digit
		logic emit;   // move one digit to the output register
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;  // output register empty or being taken
		logic last_idx;  // current digit is the least significant one
	} dp_sts_t;

endpackage

// File: sv/bta_ctrl.sv
// Controller state machine for the binary to ASCII decimal converter.
// Depends on bta_pkg; drives bta_dpath through dp_cmd_t.
module bta_ctrl #(
	parameter int NSTEP = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_valid,
	input  bta_pkg::dp_sts_t sts,
	output bta_pkg::dp_cmd_t cmd,
	output logic             in_ready
);
	import bta_pkg::*;

	localparam int CNTW = $clog2(NSTEP + 1);

	state_t            state_q, state_nxt;
	logic [CNTW-1:0]   step_q;
	logic              last_step;

	assign last_step = (step_q == CNTW'(NSTEP - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.shift) begin
				step_q <= step_q + CNTW'(1);
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_valid) state_nxt = ST_CONV;
			end
			ST_CONV: begin
				if (last_step) state_nxt = ST_SIZE;
			end
			ST_SIZE: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free && sts.last_idx) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = s_valid;
			end
			ST_CONV: begin
				cmd.shift = 1'b1;
			end
			ST_SIZE: begin
				cmd.size = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: sv/bta_dpath.sv
// Datapath: shift-and-add-3 BCD conversion, leading digit search and
// registered character output. Depends on bta_pkg; commanded by bta_ctrl.
module bta_dpath #(
	parameter int VALUE_WIDTH = 64,
	parameter int MAX_DIGITS  = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bta_pkg::dp_cmd_t          cmd,
	output bta_pkg::dp_sts_t          sts,
	input  logic [bta_pkg::IN_W-1:0]  value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [bta_pkg::CHAR_W-1:0] digit_char,
	output logic                      last_digit
);
	import bta_pkg::*;

	localparam int NSTEP = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PADW  = NSTEP * BITS_PER_STEP;
	localparam int BCD_W = MAX_DIGITS * DIGIT_BITS;
	localparam int IDXW  = $clog2(MAX_DIGITS);

	logic [PADW-1:0]       bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic                  ovf_q;   // digits lost off the top: keep leading zeros
	logic [IDXW-1:0]       idx_q;
	logic                  valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;
	logic [BCD_W:0]        step_res;
	logic [IDXW-1:0]       lead_idx;
	logic [DIGIT_BITS-1:0] cur_digit;

	// Fold BITS_PER_STEP binary bits into the BCD word, MSB first.
	// Top bit of the result flags a carry out of the top digit.
	function automatic logic [BCD_W:0] dabble(input logic [BCD_W-1:0] bcd,
	                                          input logic [BITS_PER_STEP-1:0] bits);
		logic [BCD_W-1:0]      b;
		logic                  c;
		logic [DIGIT_BITS-1:0] dg;
		b = bcd;
		c = 1'b0;
		for (int j = BITS_PER_STEP - 1; j >= 0; j--) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				dg = b[DIGIT_BITS*i +: DIGIT_BITS];
				if (dg >= 4'd5) b[DIGIT_BITS*i +: DIGIT_BITS] = dg + 4'd3;
			end
			c = c | b[BCD_W-1];
			b = {b[BCD_W-2:0], bits[j]};
		end
		return {c, b};
	endfunction

	assign step_res = dabble(bcd_q, bin_q[PADW-1 -: BITS_PER_STEP]);

	always_comb begin
		lead_idx = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[DIGIT_BITS*i +: DIGIT_BITS] != '0) lead_idx = IDXW'(i);
		end
		if (ovf_q) lead_idx = IDXW'(MAX_DIGITS - 1);
	end

	assign cur_digit = bcd_q[DIGIT_BITS*idx_q +: DIGIT_BITS];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= PADW'(value[VALUE_WIDTH-1:0]);
			bcd_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.shift) begin
			bin_q <= bin_q << BITS_PER_STEP;
			bcd_q <= step_res[BCD_W-1:0];
			ovf_q <= ovf_q | step_res[BCD_W];
		end
		if (cmd.size) begin
			idx_q <= lead_idx;
		end else if (cmd.emit) begin
			idx_q <= idx_q - IDXW'(1);
		end
		if (cmd.emit) begin
			char_q <= ASCII_ZERO + CHAR_W'(cur_digit);
			last_q <= (idx_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !valid_q || out_ready;
	assign sts.last_idx = (idx_q == '0);

	assign out_valid  = valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

endmodule

// File: sv/binary_to_ascii_decimal.sv
// Top level of the binary to ASCII decimal converter.
// Depends on bta_pkg, bta_ctrl and bta_dpath.
//
// channel  dir  tdata                          tlast
// s_axis   in   [63:0] value                   -
// m_axis   out  [5:0] digit_char, [7:6] zero   last_digit
//
// A number is converted by shift-and-add-3 (four bits per cycle), then the
// leading digit is located, then digits go out one per cycle while m_tready
// keeps the output register free.
// s_tready is high only while idle; the digit output register lets a new
// number be taken while the final digit still waits on m_tready.
// Reset clears the state machine, the step counter and the output valid flag only.
module binary_to_ascii_decimal #(
	parameter int VALUE_WIDTH = 64,
	parameter int MAX_DIGITS  = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [5:0] digit_char, [7:6] zero
	output logic       m_tlast     // last_digit
);
	import bta_pkg::*;

	localparam int NSTEP = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;

	dp_cmd_t           cmd;
	dp_sts_t           sts;
	logic [CHAR_W-1:0] digit_char;

	bta_ctrl #(
		.NSTEP(NSTEP)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.sts     (sts),
		.cmd     (cmd),
		.in_ready(s_tready)
	);

	bta_dpath #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.digit_char(digit_char),
		.last_digit(m_tlast)
	);

	assign m_tdata = {2'b00, digit_char};

	// Accepting a number always leaves the idle state.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready after an item was accepted");

	// Only decimal digit characters are ever presented.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:0] >= 6'd48) && (m_tdata[5:0] <= 6'd57))
		else $error("output character outside the decimal digits");

	// While idle, a pending output can only be the closing digit of a run.
	a_idle_pending_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tlast)
		else $error("idle with a non-final digit still pending");

endmodule

// File: sim/tb_binary_to_ascii_decimal.sv
// Self-checking testbench for binary_to_ascii_decimal: numbers in on s_axis, digits out on m_axis.
// A table of directed numbers is followed by random ones, with random idling on both sides.
// Depends on bta_pkg and the binary_to_ascii_decimal RTL.
module tb_binary_to_ascii_decimal;
	timeunit 1ns;
	timeprecision 1ps;

	import bta_pkg::*;

	localparam int VALUE_WIDTH = 64;
	localparam int MAX_DIGITS  = 20;
	localparam int DIGIT_LIMIT = (MAX_DIGITS < 1) ? 1 : ((MAX_DIGITS > 20) ? 20 : MAX_DIGITS);
	localparam logic [63:0] VALUE_MASK =
		(VALUE_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
	localparam int NUM_RANDOM  = 150;
	localparam int DRAIN_TICKS = 60;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} char_item_t;

	typedef struct {
		logic [63:0] value;
		string       text;   // empty: expected digits come from the converter model
	} dir_row_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [63:0] s_tdata = '0;   // [63:0] value
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;         // [5:0] digit_char, [7:6] zero
	logic       m_tlast;         // last_digit

	char_item_t expected_chars[$];
	char_item_t head_char;
	int         errors = 0;
	bit         quiet  = 1'b0;   // set during stretches with no idling

	dir_row_t dir_rows [18] = '{
		'{64'd0,                    "0"},
		'{64'd1,                    "1"},
		'{64'd9,                    "9"},
		'{64'd10,                   "10"},
		'{64'd99,                   ""},
		'{64'd100,                  ""},
		'{64'd42,                   ""},
		'{64'd255,                  ""},
		'{64'd65535,                ""},
		'{64'h0000_0001_0000_0000,  ""},
		'{64'd9999999999999999999,  "9999999999999999999"},
		'{64'd10000000000000000000, "10000000000000000000"},
		'{64'd12345678901234567890, ""},
		'{64'h7FFF_FFFF_FFFF_FFFF,  "9223372036854775807"},
		'{64'h8000_0000_0000_0000,  "9223372036854775808"},
		'{64'hAAAA_AAAA_AAAA_AAAA,  ""},
		'{64'h5555_5555_5555_5555,  ""},
		'{64'hFFFF_FFFF_FFFF_FFFF,  "18446744073709551615"}
	};

	binary_to_ascii_decimal #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.MAX_DIGITS (MAX_DIGITS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always #6 clk = ~clk;

	// Queue the digits of a number, most significant first.
	function automatic void queue_decimal(input logic [63:0] value);
		logic [63:0] rest;
		logic [3:0]  digs [20];
		int          count;
		char_item_t  c;
		rest  = value & VALUE_MASK;
		count = 0;
		do begin
			digs[count] = 4'(rest % 64'd10);
			rest        = rest / 64'd10;
			count++;
		end while (rest != 64'd0 && count < DIGIT_LIMIT);
		for (int k = 0; k < count; k++) begin
			c.digit_char = ASCII_ZERO + CHAR_W'(digs[count - 1 - k]);
			c.last_digit = (k == count - 1);
			expected_chars.push_back(c);
		end
	endfunction

	function automatic void queue_text(input string text);
		byte        b;
		char_item_t c;
		for (int i = 0; i < text.len(); i++) begin
			b            = text[i];
			c.digit_char = b[CHAR_W-1:0];
			c.last_digit = (i == text.len() - 1);
			expected_chars.push_back(c);
		end
	endfunction

	function automatic logic [63:0] pow10(input int k);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < k; i++)
			p = p * 64'd10;
		return p;
	endfunction

	// Mostly uniform over digit counts, some raw bit patterns, some powers of ten +/- 1.
	function automatic logic [63:0] rand_value();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] raw;
		int          sel;
		int          d;
		sel = $urandom_range(0, 9);
		raw = {$urandom, $urandom};
		if (sel < 2)
			return raw;
		if (sel == 2)
			return pow10($urandom_range(0, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
		d  = $urandom_range(1, 20);
		lo = (d == 1) ? 64'd0 : pow10(d - 1);
		hi = (d == 20) ? {64{1'b1}} : pow10(d) - 64'd1;
		return lo + raw % (hi - lo + 64'd1);
	endfunction

	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_number(input logic [63:0] value, input string text);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (text.len() > 0)
			queue_text(text);
		else
			queue_decimal(value);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_number(dir_rows[i].value, dir_rows[i].text);
		for (int i = 0; i < NUM_RANDOM; i++) begin
			quiet = ((i / 25) % 3 == 2);
			send_number(rand_value(), "");
		end
		s_tvalid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);
		if (errors == 0 && expected_chars.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Sink side: random stalls on m_tready.
	initial begin
		@(posedge arst_n);
		forever begin
			int gap;
			gap = gap_len();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat (1 + $urandom_range(0, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected digit item: tdata %0h tlast %0b", m_tdata, m_tlast);
				errors++;
			end else begin
				head_char = expected_chars.pop_front();
				if (m_tdata[CHAR_W-1:0] !== head_char.digit_char) begin
					$error("digit_char: expected %0d, got %0d",
						head_char.digit_char, m_tdata[CHAR_W-1:0]);
					errors++;
				end
				if (m_tlast !== head_char.last_digit) begin
					$error("last_digit: expected %0b, got %0b", head_char.last_digit, m_tlast);
					errors++;
				end
				if (m_tdata[7:CHAR_W] !== '0) begin
					$error("zero: expected 0, got %0d", m_tdata[7:CHAR_W]);
					errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
